// ----- src/tdss_pkg.sv -----
// Package for the two-digit segment serialiser: constants, payload types and
// the segment table. No dependencies.
package tdss_pkg;

  localparam int unsigned FrameBits = 16;
  localparam int unsigned CntW      = $clog2(FrameBits);
  localparam int unsigned ValueW    = 16;
  localparam int unsigned QuotW     = 13;  // 65535 / 10 = 6553
  localparam int unsigned DigitW    = 4;

  // x / 10 == (x * 52429) >> 19 holds for every x below 2**16.
  localparam logic [15:0] DivTenMul   = 16'd52429;
  localparam int unsigned DivTenShift = 19;

  localparam logic [7:0] SelTens = 8'hFE;
  localparam logic [7:0] SelOnes = 8'hFD;

  typedef struct packed {
    logic [QuotW-1:0]  quot;  // value / 10
    logic [DigitW-1:0] ones;  // value % 10
  } tdss_split_t;

  // Segment pattern, bit 0 = segment a up to bit 6 = segment g, active high.
  function automatic logic [7:0] seg_pattern(input logic [DigitW-1:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ----- src/tdss_if.sv -----
// Handshake interfaces for the value requests and the serial-bit results.
// Depends on tdss_pkg for field widths.
interface tdss_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdss_pkg::ValueW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdss_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_after;

  modport source (output valid, output serial_bit, output latch_after, input ready);
  modport sink   (input valid, input serial_bit, input latch_after, output ready);
endinterface

// ----- src/tdss_input_stage.sv -----
// Input register: takes a request and stores value / 10 and value % 10.
// Depends on tdss_pkg and tdss_if.
module tdss_input_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tdss_in_if.sink               req_i,
  input  logic                  take_i,
  output logic                  valid_o,
  output tdss_pkg::tdss_split_t data_o
);

  logic                         valid_q;
  tdss_pkg::tdss_split_t        data_q;
  tdss_pkg::tdss_split_t        data_d;
  logic [31:0]                  prod;
  logic [tdss_pkg::ValueW-1:0]  rem;

  assign req_i.ready = !valid_q || take_i;

  always_comb begin
    prod        = 32'(req_i.value) * 32'(tdss_pkg::DivTenMul);
    data_d.quot = prod[tdss_pkg::DivTenShift +: tdss_pkg::QuotW];
    rem         = req_i.value - (16'(data_d.quot) * 16'd10);
    data_d.ones = rem[tdss_pkg::DigitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/tdss_frame_shifter.sv -----
// Digit choice, frame build and the 16-bit output shift register.
// Depends on tdss_pkg and tdss_if.
module tdss_frame_shifter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  tdss_pkg::tdss_split_t data_i,
  output logic                  take_o,
  tdss_out_if.source            res_o
);

  logic [tdss_pkg::FrameBits-1:0] frame_q;
  logic [tdss_pkg::FrameBits-1:0] frame_d;
  logic [tdss_pkg::CntW-1:0]      cnt_q;
  logic                           busy_q;
  logic                           tens_turn_q;
  logic [28:0]                    prod;
  logic [9:0]                     quot2;
  logic [tdss_pkg::QuotW-1:0]     rem;
  logic [tdss_pkg::DigitW-1:0]    digit;
  logic                           last;
  logic                           pop;
  logic                           load;

  always_comb begin
    // Tens digit is (value / 10) % 10, taken from the stored quotient.
    prod    = 29'(data_i.quot) * 29'(tdss_pkg::DivTenMul);
    quot2   = prod[tdss_pkg::DivTenShift +: 10];
    rem     = data_i.quot - (13'(quot2) * 13'd10);
    digit   = tens_turn_q ? rem[tdss_pkg::DigitW-1:0] : data_i.ones;
    frame_d = {(tens_turn_q ? tdss_pkg::SelTens : tdss_pkg::SelOnes),
               tdss_pkg::seg_pattern(digit)};
  end

  assign last   = (cnt_q == tdss_pkg::CntW'(tdss_pkg::FrameBits - 1));
  assign pop    = busy_q && res_o.ready;
  assign load   = valid_i && (!busy_q || (pop && last));
  assign take_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      tens_turn_q <= 1'b1;
    end else if (load) begin
      busy_q      <= 1'b1;
      cnt_q       <= '0;
      tens_turn_q <= !tens_turn_q;
    end else if (pop) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_d;
    end else if (pop) begin
      frame_q <= {frame_q[tdss_pkg::FrameBits-2:0], 1'b0};
    end
  end

  assign res_o.valid       = busy_q;
  assign res_o.serial_bit  = frame_q[tdss_pkg::FrameBits-1];
  assign res_o.latch_after = last;

endmodule

// ----- src/two_digit_segment_serializer.sv -----
// Top level of the two-digit segment serialiser.
// Depends on tdss_pkg, tdss_if, tdss_input_stage and tdss_frame_shifter.
//
//   Port    Direction  Handshake    Payload
//   req_i   in         valid/ready  value[15:0]
//   res_o   out        valid/ready  serial_bit, latch_after
//
// Each request yields 16 results, one per cycle while res_o.ready is high,
// frame MSB first; latch_after marks the sixteenth. The shift register sets
// the rate of requests. A second request waits in the input register, and
// moves into the shift register in the cycle the last bit goes.
// Reset is asynchronous, active low, and makes the first frame a tens frame.
// A stall on res_o holds the current bit and backs up into req_i.ready.
module two_digit_segment_serializer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdss_in_if.sink    req_i,
  tdss_out_if.source res_o
);

  logic                  stage_valid;
  logic                  stage_take;
  tdss_pkg::tdss_split_t stage_data;

  tdss_input_stage u_input_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (stage_take),
    .valid_o (stage_valid),
    .data_o  (stage_data)
  );

  tdss_frame_shifter u_frame_shifter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .data_i  (stage_data),
    .take_o  (stage_take),
    .res_o   (res_o)
  );

endmodule

// ----- dv/two_digit_segment_serializer_tb.sv -----
`timescale 1ns / 1ps
// Testbench for two_digit_segment_serializer: drives value requests, predicts the
// 16 serial bits of every frame and checks them in order. Depends on tdss_pkg and tdss_if.
module two_digit_segment_serializer_tb;

  // Tracks the digit toggle and keeps the serial bits still owed by the block.
  class seg_frame_board;
    typedef struct packed {
      logic serial_bit;
      logic latch_after;
    } seg_bit_t;

    seg_bit_t    bits_due[$];
    bit          tens_turn;
    int unsigned errors;
    logic [7:0]  seg_lut[10];

    function new();
      tens_turn = 1'b1;
      errors    = 0;
      seg_lut   = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
    endfunction

    function int unsigned pending();
      return bits_due.size();
    endfunction

    function void note_value(input logic [tdss_pkg::ValueW-1:0] value);
      int unsigned digit;
      logic [7:0]  sel;
      logic [15:0] frame;
      seg_bit_t    sb;
      if (tens_turn) begin
        digit = (int'(value) / 10) % 10;
        sel   = tdss_pkg::SelTens;
      end else begin
        digit = int'(value) % 10;
        sel   = tdss_pkg::SelOnes;
      end
      tens_turn = !tens_turn;
      frame = {sel, seg_lut[digit]};
      for (int k = 15; k >= 0; k--) begin
        sb.serial_bit  = frame[k];
        sb.latch_after = (k == 0);
        bits_due.push_back(sb);
      end
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_bit(input logic serial_bit, input logic latch_after);
      seg_bit_t want;
      if (bits_due.size() == 0) begin
        report_mismatch($sformatf("unexpected bit %b latch %b", serial_bit, latch_after));
      end else begin
        want = bits_due.pop_front();
        if (serial_bit !== want.serial_bit)
          report_mismatch($sformatf("serial_bit %b, want %b", serial_bit, want.serial_bit));
        if (latch_after !== want.latch_after)
          report_mismatch($sformatf("latch_after %b, want %b", latch_after, want.latch_after));
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tdss_in_if  req_if ();
  tdss_out_if res_if ();

  two_digit_segment_serializer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  seg_frame_board board = new();

  bit          calm     = 1'b0;  // no idling on either side
  int unsigned hold_ask = 0;     // long receiver hold-off, handed to the receiver

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold-off counted here.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left    = 0;
    stall_left   = 0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (hold_left != 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 9) - 1;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      board.check_bit(res_if.serial_bit, res_if.latch_after);
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a back-to-back request needs no second assignment.
  task automatic send_value(input logic [tdss_pkg::ValueW-1:0] value);
    req_if.valid = 1'b1;
    req_if.value = value;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_value(value);
    @(negedge clk_i);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      req_if.value = tdss_pkg::ValueW'($urandom);
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  function automatic logic [tdss_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return tdss_pkg::ValueW'($urandom_range(0, 99));
      1:       return tdss_pkg::ValueW'($urandom_range(100, 999));
      2:       return tdss_pkg::ValueW'($urandom);
      default: return tdss_pkg::ValueW'($urandom_range(65436, 65535));
    endcase
  endfunction

  initial begin : stimulus
    logic [tdss_pkg::ValueW-1:0] directed[$];
    req_if.valid = 1'b0;
    req_if.value = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every digit on both turns (zero tens digit first), then wide values.
    for (int d = 0; d < 10; d++) begin
      directed.push_back(tdss_pkg::ValueW'(11 * d));
      directed.push_back(tdss_pkg::ValueW'(11 * d));
    end
    directed = {directed, 16'd100, 16'hFFFF, 16'hFFFF, 16'd10, 16'd12345};
    foreach (directed[i]) begin
      maybe_pause();
      send_value(directed[i]);
    end

    // The receiver holds off for a long while and the sender keeps offering.
    hold_ask = 150;
    for (int i = 0; i < 6; i++)
      send_value(pick_value());
    req_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);

    for (int i = 0; i < 340; i++) begin
      if (i == 280)
        calm = 1'b1;
      maybe_pause();
      send_value(pick_value());
    end
    req_if.valid = 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
